### rtl/core/refe_pkg.sv
// refe_pkg: shared types, character constants and header lookup for the
// reply/event frame extractor. No dependencies.
`default_nettype none

package refe_pkg;

  localparam logic [7:0] ChOpen  = 8'h3C;  // '<'
  localparam logic [7:0] ChClose = 8'h3E;  // '>'
  localparam logic [7:0] ChE     = 8'h45;
  localparam logic [7:0] ChN     = 8'h4E;
  localparam logic [7:0] ChD     = 8'h44;

  localparam logic [1:0] ModeSearch = 2'd0;
  localparam logic [1:0] ModeHeader = 2'd1;
  localparam logic [1:0] ModeBody   = 2'd2;

  // header is '<' plus a five letter name
  localparam logic [2:0] HdrLen  = 3'd6;
  localparam logic [2:0] HdrLast = 3'd5;
  // "<END" fully matched
  localparam logic [2:0] EndDone = 3'd4;

  typedef struct packed {
    logic [1:0] scan_mode;
    logic [2:0] header_count;
    logic       reply_candidate;
    logic       event_candidate;
    logic [2:0] end_match_progress;
    logic       current_kind;
  } scan_state_t;

  // what one input byte leaves for the output stage
  typedef struct packed {
    logic       emit;
    logic       header;
    logic       kind;
    logic [7:0] data;
    logic       last;
  } result_desc_t;

  // letter i (0..4) of the frame name
  function automatic logic [7:0] name_char(input logic reply, input logic [2:0] i);
    logic [7:0] c;
    c = 8'h00;
    if (reply) begin
      case (i)
        3'd0: c = 8'h52;  // R
        3'd1: c = 8'h45;  // E
        3'd2: c = 8'h50;  // P
        3'd3: c = 8'h4C;  // L
        3'd4: c = 8'h59;  // Y
        default: c = 8'h00;
      endcase
    end else begin
      case (i)
        3'd0: c = 8'h45;  // E
        3'd1: c = 8'h56;  // V
        3'd2: c = 8'h45;  // E
        3'd3: c = 8'h4E;  // N
        3'd4: c = 8'h54;  // T
        default: c = 8'h00;
      endcase
    end
    return c;
  endfunction

  // "<END" character at match position p (0..3)
  function automatic logic [7:0] end_char(input logic [1:0] p);
    logic [7:0] c;
    case (p)
      2'd0: c = ChOpen;
      2'd1: c = ChE;
      2'd2: c = ChN;
      default: c = ChD;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

### rtl/core/refe_scan.sv
// refe_scan: combinational next-state and result logic for one byte.
// Depends on refe_pkg.
`default_nettype none

module refe_scan
  import refe_pkg::*;
(
  input  wire scan_state_t  cur,
  input  wire logic [7:0]   data,
  output scan_state_t       nxt,
  output result_desc_t      res
);

  logic       is_open;
  logic       rc_n;
  logic       ec_n;
  logic [2:0] name_idx;

  assign is_open  = (data == ChOpen);
  assign name_idx = cur.header_count - 3'd1;
  assign rc_n     = cur.reply_candidate && (data == name_char(1'b1, name_idx));
  assign ec_n     = cur.event_candidate && (data == name_char(1'b0, name_idx));

  always_comb begin
    nxt = cur;
    res.emit   = 1'b0;
    res.header = 1'b0;
    res.kind   = cur.current_kind;
    res.data   = data;
    res.last   = 1'b0;
    case (cur.scan_mode)
      ModeHeader: begin
        if (cur.header_count < 3'd1 || cur.header_count > 3'd5 || (!rc_n && !ec_n)) begin
          // partial header dropped; a '<' opens a new one
          nxt.scan_mode       = ModeSearch;
          nxt.header_count    = 3'd0;
          nxt.reply_candidate = 1'b0;
          nxt.event_candidate = 1'b0;
          if (is_open) begin
            nxt.scan_mode       = ModeHeader;
            nxt.header_count    = 3'd1;
            nxt.reply_candidate = 1'b1;
            nxt.event_candidate = 1'b1;
          end
        end else if (cur.header_count + 3'd1 < HdrLen) begin
          nxt.header_count    = cur.header_count + 3'd1;
          nxt.reply_candidate = rc_n;
          nxt.event_candidate = ec_n;
        end else begin
          // header confirmed: emit the six-beat burst
          nxt.scan_mode          = ModeBody;
          nxt.header_count       = 3'd0;
          nxt.reply_candidate    = 1'b0;
          nxt.event_candidate    = 1'b0;
          nxt.end_match_progress = 3'd0;
          nxt.current_kind       = rc_n;
          res.emit   = 1'b1;
          res.header = 1'b1;
          res.kind   = rc_n;
        end
      end
      ModeBody: begin
        res.emit = 1'b1;
        if (cur.end_match_progress >= EndDone) begin
          if (data == ChClose) begin
            res.last               = 1'b1;
            nxt.scan_mode          = ModeSearch;
            nxt.end_match_progress = 3'd0;
          end
        end else if (data == end_char(cur.end_match_progress[1:0])) begin
          nxt.end_match_progress = cur.end_match_progress + 3'd1;
        end else begin
          nxt.end_match_progress = is_open ? 3'd1 : 3'd0;
        end
      end
      default: begin
        // searching, also the unused mode code
        nxt.scan_mode = ModeSearch;
        if (is_open) begin
          nxt.scan_mode       = ModeHeader;
          nxt.header_count    = 3'd1;
          nxt.reply_candidate = 1'b1;
          nxt.event_candidate = 1'b1;
        end
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/core/reply_event_frame_extractor.sv
// reply_event_frame_extractor: top level, input register, scan state and
// output burst stage. Depends on refe_pkg and refe_scan.
//
//   channel  handshake           payload
//   in       in_valid/in_ready   rx_byte
//   out      out_valid/out_ready out_byte, frame_first, frame_last,
//                                frame_is_reply, run_last
//
// A body byte gives one beat; a confirming header byte gives six beats
// from the output stage, during which input holds once the input register
// is full. Bytes outside frames give no beat. An accepted byte passes the
// input register, then the output stage, before its first beat.
// Synchronous active-high reset clears the scan state and both valid flags.
`default_nettype none

module reply_event_frame_extractor
  import refe_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [7:0] rx_byte,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [7:0]      out_byte,
  output logic            frame_first,
  output logic            frame_last,
  output logic            frame_is_reply,
  output logic            run_last
);

  // input register
  logic       inr_valid;
  logic [7:0] inr_byte;

  // scan state
  scan_state_t  state;
  scan_state_t  state_next;
  result_desc_t desc;

  // output stage
  logic       slot_valid;
  logic       slot_header;
  logic [2:0] slot_idx;
  logic [7:0] slot_byte;
  logic       slot_last;
  logic       slot_kind;

  logic slot_final;
  logic advance;

  refe_scan u_scan (
    .cur  (state),
    .data (inr_byte),
    .nxt  (state_next),
    .res  (desc)
  );

  // output fields from the stage
  assign out_valid      = slot_valid;
  assign out_byte       = !slot_header ? slot_byte :
                          (slot_idx == 3'd0) ? ChOpen :
                          name_char(slot_kind, slot_idx - 3'd1);
  assign frame_first    = slot_header && (slot_idx == 3'd0);
  assign frame_last     = !slot_header && slot_last;
  assign frame_is_reply = slot_kind;
  assign run_last       = !slot_header || (slot_idx == HdrLast);

  // stage frees up on the last beat of its burst
  assign slot_final = slot_valid && out_ready && run_last;
  assign advance    = inr_valid && (!slot_valid || slot_final);
  assign in_ready   = !inr_valid || advance;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      inr_valid <= 1'b0;
    end else if (in_ready) begin
      inr_valid <= in_valid;
    end
    if (in_ready && in_valid) begin
      inr_byte <= rx_byte;
    end
  end

  // scan state update as a byte moves into the output stage
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (advance) begin
      state <= state_next;
    end
  end

  // output stage and header burst counter
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= 1'b0;
      slot_idx   <= 3'd0;
    end else if (advance) begin
      slot_valid <= desc.emit;
      slot_idx   <= 3'd0;
    end else if (slot_final) begin
      slot_valid <= 1'b0;
    end else if (slot_valid && out_ready) begin
      slot_idx <= slot_idx + 3'd1;
    end
    if (advance) begin
      slot_header <= desc.header;
      slot_byte   <= desc.data;
      slot_last   <= desc.last;
      slot_kind   <= desc.kind;
    end
  end

endmodule

`default_nettype wire

### tb/refe_checker.sv
// refe_checker: watches both channels of the reply/event frame extractor,
// predicts the output beats of every accepted byte and compares them in order.
// Depends on refe_pkg for character and scan mode constants.
`timescale 1ns / 1ps

module refe_checker
  import refe_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  input  wire logic       in_ready,
  input  wire logic [7:0] rx_byte,
  input  wire logic       out_valid,
  input  wire logic       out_ready,
  input  wire logic [7:0] out_byte,
  input  wire logic       frame_first,
  input  wire logic       frame_last,
  input  wire logic       frame_is_reply,
  input  wire logic       run_last,
  output int              fail_count,
  output int              pending,
  output int              beats_seen,
  output int              frames_closed
);

  localparam logic [39:0] ReplyName = "REPLY";
  localparam logic [39:0] EventName = "EVENT";
  localparam logic [31:0] EndMark   = "<END";

  typedef struct packed {
    logic [7:0] data;
    logic       first;
    logic       last;
    logic       reply;
    logic       run_end;
  } frame_beat_t;

  scan_state_t  scan;
  frame_beat_t  expected_beats[$];
  frame_beat_t  want;
  frame_beat_t  got;
  int           bad;
  int           reports_left = 200;

  // letter i of the five letter frame name
  function automatic logic [7:0] name_letter(input logic reply, input int i);
    logic [39:0] word;
    word = reply ? ReplyName : EventName;
    return word[39 - 8*i -: 8];
  endfunction

  function automatic int field_diff(input string what, input logic [7:0] want_v,
                                    input logic [7:0] got_v);
    if (want_v === got_v) return 0;
    if (reports_left > 0) begin
      reports_left--;
      $display("%0t: %s mismatch, expected %02h, got %02h", $time, what, want_v, got_v);
    end
    return 1;
  endfunction

  task automatic push_beat(input logic [7:0] data, input logic first, input logic last,
                           input logic reply, input logic run_end);
    frame_beat_t beat;
    beat.data    = data;
    beat.first   = first;
    beat.last    = last;
    beat.reply   = reply;
    beat.run_end = run_end;
    expected_beats.push_back(beat);
  endtask

  task automatic open_header();
    scan.scan_mode       = ModeHeader;
    scan.header_count    = 3'd1;
    scan.reply_candidate = 1'b1;
    scan.event_candidate = 1'b1;
  endtask

  // advance the scan state by one byte and queue the beats it gives
  task automatic predict_beats(input logic [7:0] b);
    int   idx;
    int   i;
    logic kind;
    logic closing;
    case (scan.scan_mode)
      ModeHeader: begin
        idx = int'(scan.header_count);
        if (idx < 1 || idx > 5) begin
          // count out of range: back to searching
          scan.scan_mode       = ModeSearch;
          scan.header_count    = 3'd0;
          scan.reply_candidate = 1'b0;
          scan.event_candidate = 1'b0;
          if (b == ChOpen) open_header();
        end else begin
          if (b != name_letter(1'b1, idx - 1)) scan.reply_candidate = 1'b0;
          if (b != name_letter(1'b0, idx - 1)) scan.event_candidate = 1'b0;
          if (!scan.reply_candidate && !scan.event_candidate) begin
            // header broken: drop it, a '<' opens a fresh one
            scan.scan_mode    = ModeSearch;
            scan.header_count = 3'd0;
            if (b == ChOpen) open_header();
          end else begin
            scan.header_count = 3'(idx + 1);
            if (scan.header_count == HdrLen) begin
              // header confirmed: six beats rebuilt from the kind
              kind = scan.reply_candidate;
              scan.current_kind = kind;
              push_beat(ChOpen, 1'b1, 1'b0, kind, 1'b0);
              for (i = 0; i < 5; i++) begin
                push_beat(name_letter(kind, i), 1'b0, 1'b0, kind, i == 4);
              end
              scan.scan_mode          = ModeBody;
              scan.header_count       = 3'd0;
              scan.reply_candidate    = 1'b0;
              scan.event_candidate    = 1'b0;
              scan.end_match_progress = 3'd0;
            end
          end
        end
      end
      ModeBody: begin
        closing = 1'b0;
        if (scan.end_match_progress >= EndDone) begin
          closing = (b == ChClose);
        end else if (b == EndMark[31 - 8*int'(scan.end_match_progress) -: 8]) begin
          scan.end_match_progress = scan.end_match_progress + 3'd1;
        end else begin
          scan.end_match_progress = (b == ChOpen) ? 3'd1 : 3'd0;
        end
        push_beat(b, 1'b0, closing, scan.current_kind, 1'b1);
        if (closing) begin
          scan.scan_mode          = ModeSearch;
          scan.end_match_progress = 3'd0;
        end
      end
      default: begin
        scan.scan_mode = ModeSearch;
        if (b == ChOpen) open_header();
      end
    endcase
  endtask

  // compare output beats, then predict from the accepted input beat
  always @(posedge clk) begin
    if (rst) begin
      scan = '0;
      expected_beats.delete();
      pending       <= 0;
      fail_count    <= 0;
      beats_seen    <= 0;
      frames_closed <= 0;
    end else begin
      if (out_valid && out_ready) begin
        got.data    = out_byte;
        got.first   = frame_first;
        got.last    = frame_last;
        got.reply   = frame_is_reply;
        got.run_end = run_last;
        beats_seen <= beats_seen + 1;
        if (frame_last === 1'b1) frames_closed <= frames_closed + 1;
        if (expected_beats.size() == 0) begin
          $display("%0t: unexpected beat, got byte=%02h first=%b last=%b reply=%b run_last=%b",
                   $time, out_byte, frame_first, frame_last, frame_is_reply, run_last);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_beats.pop_front();
          bad = field_diff("out_byte", want.data, got.data)
              + field_diff("frame_first", 8'(want.first), 8'(got.first))
              + field_diff("frame_last", 8'(want.last), 8'(got.last))
              + field_diff("frame_is_reply", 8'(want.reply), 8'(got.reply))
              + field_diff("run_last", 8'(want.run_end), 8'(got.run_end));
          if (bad != 0) fail_count <= fail_count + 1;
        end
      end
      if (in_valid && in_ready) predict_beats(rx_byte);
      pending <= expected_beats.size();
    end
  end

endmodule

### tb/tb_top.sv
// tb_top: clock, reset and byte stream stimulus for reply_event_frame_extractor,
// with a random stalling receiver. Depends on refe_pkg, the block and refe_checker.
`timescale 1ns / 1ps

module tb_top
  import refe_pkg::*;
();

  localparam int CycleLimit = 400000;
  localparam logic [39:0] MarkChars = "<END>";

  typedef enum logic [1:0] {ReadyAlways, ReadyRandom, ReadyRuns} ready_style_e;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic [7:0] rx_byte = 8'h00;
  logic       out_ready = 1'b0;
  logic       in_ready;
  logic       out_valid;
  logic [7:0] out_byte;
  logic       frame_first;
  logic       frame_last;
  logic       frame_is_reply;
  logic       run_last;

  int fail_count;
  int pending;
  int beats_seen;
  int frames_closed;

  int cycle_count = 0;
  int burst_left = 0;
  int bytes_sent = 0;
  int frame_bytes = 0;
  bit paused = 1'b0;

  ready_style_e ready_style = ReadyAlways;
  int           style_left = 0;
  int           stall_left = 0;

  reply_event_frame_extractor DUT (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .rx_byte       (rx_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .frame_first   (frame_first),
    .frame_last    (frame_last),
    .frame_is_reply(frame_is_reply),
    .run_last      (run_last)
  );

  refe_checker frame_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .rx_byte       (rx_byte),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_byte      (out_byte),
    .frame_first   (frame_first),
    .frame_last    (frame_last),
    .frame_is_reply(frame_is_reply),
    .run_last      (run_last),
    .fail_count    (fail_count),
    .pending       (pending),
    .beats_seen    (beats_seen),
    .frames_closed (frames_closed)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("%0t: timeout after %0d cycles, %0d beats outstanding",
               $time, cycle_count, pending);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver: picks a new stall style each time its style countdown runs out
  always @(posedge clk) begin
    if (rst) begin
      out_ready  <= 1'b0;
      style_left <= 0;
      stall_left <= 0;
    end else begin
      if (style_left == 0) begin
        ready_style <= ready_style_e'($urandom_range(0, 2));
        style_left  <= $urandom_range(50, 300);
      end else begin
        style_left <= style_left - 1;
      end
      case (ready_style)
        ReadyAlways: out_ready <= 1'b1;
        ReadyRandom: out_ready <= ($urandom_range(0, 3) != 0);
        default: begin
          if (stall_left != 0) begin
            stall_left <= stall_left - 1;
            out_ready  <= 1'b0;
          end else if ($urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(1, 8);
            out_ready  <= 1'b0;
          end else begin
            out_ready <= 1'b1;
          end
        end
      endcase
    end
  end

  // one input beat, sent in bursts with random gaps between them
  task automatic send_byte(input logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    in_valid <= 1'b1;
    rx_byte  <= b;
    do @(posedge clk); while (in_ready !== 1'b1);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    int i;
    for (i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // hold the input until every predicted beat has come out
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // body bytes lean toward the characters of the end mark
  function automatic logic [7:0] body_byte();
    case ($urandom_range(0, 3))
      0, 1: return 8'($urandom_range(0, 255));
      2: return MarkChars[8*$urandom_range(0, 4) +: 8];
      default: return ($urandom_range(0, 1) != 0) ? ChOpen : ChClose;
    endcase
  endfunction

  // complete frame with random body and near misses of the end mark
  task automatic send_frame(input logic reply);
    int start;
    int n;
    start = bytes_sent;
    send_text(reply ? "<REPLY" : "<EVENT");
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 10);
    repeat (n) send_byte(body_byte());
    case ($urandom_range(0, 3))
      0: send_text("<EN");
      1: send_text("<E<");
      default: ;
    endcase
    send_text("<END");
    if ($urandom_range(0, 2) == 0) send_byte(8'($urandom_range(0, 255)));
    send_byte(ChClose);
    frame_bytes += bytes_sent - start;
  endtask

  // '<' and a partial name, then a byte that may or may not break it
  task automatic send_broken_header();
    string name;
    int    n;
    int    i;
    name = ($urandom_range(0, 1) != 0) ? "REPLY" : "EVENT";
    n = $urandom_range(0, 4);
    send_byte(ChOpen);
    for (i = 0; i < n; i++) send_byte(name[i]);
    send_byte(($urandom_range(0, 1) != 0) ? ChOpen : 8'($urandom_range(0, 255)));
  endtask

  initial begin
    int pick;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // directed: header restarts, body near misses, byte extremes
    send_text("<X");
    send_text("<R<EVENT");
    send_text(">");
    send_text("<E");
    send_byte(8'h00);
    send_text("<E<END");
    send_byte(8'hFF);
    send_byte(ChClose);
    send_text("<REPLY");
    drain();

    // random: mostly well formed frames, some broken headers and noise
    while (bytes_sent < 400) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        send_frame(1'($urandom_range(0, 1)));
      end else if (pick < 9) begin
        send_broken_header();
      end else begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
      end
      if (!paused && bytes_sent >= 200) begin
        drain();
        paused = 1'b1;
      end
    end

    drain();
    repeat (10) @(posedge clk);
    $display("Sent %0d input bytes (%0d inside random frames), checked %0d output beats",
             bytes_sent, frame_bytes, beats_seen);
    $display("covering %0d closed frames of both kinds", frames_closed);
    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/refe_pkg.sv
rtl/core/refe_scan.sv
rtl/core/reply_event_frame_extractor.sv
tb/refe_checker.sv
tb/tb_top.sv
